[rtl/assert_macros.svh]
// assertion macros used by frequent_item_support_ranker.sv
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on the rising clock edge, off during reset
`define FISR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// next-cycle implication sampled on the rising clock edge
`define FISR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fisr_pkg.sv]
// shared types and constants of the frequent item support ranker
// no dependencies
package fisr_pkg;

    localparam int NUM_ITEMS    = 64;
    localparam int SUPPORT_BITS = 20;

    localparam int ITEM_IDX_W = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
    localparam int FREQ_W     = $clog2(NUM_ITEMS + 1);

    // fixed field widths
    localparam int ACTION_W   = 2;
    localparam int TSIZE_W    = 8;
    localparam int ID_W       = 6;
    localparam int RANK_W     = 6;
    localparam int SUP_FLD_W  = 20;
    localparam int FCOUNT_W   = 7;
    localparam int MINSUP_W   = 20;
    localparam int EXPK_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam int THR_W = (SUPPORT_BITS > MINSUP_W) ? SUPPORT_BITS : MINSUP_W;

    localparam logic [SUPPORT_BITS-1:0] SUPPORT_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SUPPORT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_K  = CFG_IDX_W'(1);

    typedef enum logic [ACTION_W-1:0] {
        ACT_HEADER = 2'd0,
        ACT_ITEM   = 2'd1,
        ACT_FINISH = 2'd2
    } action_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [TSIZE_W-1:0]  trans_size;
        logic [ID_W-1:0]     item_id;
    } fisr_in_t;

    typedef struct packed {
        logic [RANK_W-1:0]    rank;
        logic [ID_W-1:0]      ranked_item;
        logic [SUP_FLD_W-1:0] item_support;
        logic                 is_frequent;
        logic [FCOUNT_W-1:0]  frequent_count;
        logic [TSIZE_W-1:0]   size_limit;
        logic                 last;
    } fisr_out_t;

    // sequencer commands to the rank unit
    typedef struct packed {
        logic load;
        logic step;
    } fisr_rank_ctl_t;

endpackage

[rtl/fisr_rank_unit.sv]
// rank position unit: holds one pivot item and counts items that sort ahead of it
// depends on fisr_pkg
module fisr_rank_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fisr_pkg::fisr_rank_ctl_t       ctl,
    input  logic [fisr_pkg::SUPPORT_BITS-1:0] sup,
    input  logic [fisr_pkg::ITEM_IDX_W-1:0]   id,
    output logic [fisr_pkg::ITEM_IDX_W-1:0]   pos
);
    import fisr_pkg::*;

    logic [SUPPORT_BITS-1:0] pivot_sup_reg;
    logic [ITEM_IDX_W-1:0]   pivot_id_reg;
    logic [ITEM_IDX_W-1:0]   pos_reg;
    logic                    ahead;

    // higher support first, smaller id on a tie
    assign ahead = (sup > pivot_sup_reg) || ((sup == pivot_sup_reg) && (id < pivot_id_reg));

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            pivot_sup_reg <= sup;
            pivot_id_reg  <= id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (ctl.load)
        begin
            pos_reg <= '0;
        end
        else if (ctl.step && ahead)
        begin
            pos_reg <= pos_reg + 1'b1;
        end
    end

    assign pos = pos_reg;

endmodule

[rtl/frequent_item_support_ranker.sv]
// frequent item support ranker, top level: support counters, sequencer, result port
// depends on fisr_pkg, fisr_rank_unit and assert_macros.svh
//
// first pass of frequent itemset mining. a header word (action 0) raises the
// largest transaction size; an item word (action 1) bumps that item's saturating
// support counter by a read-modify-write of the counter memory, read in idle and
// written back in the inc state. a finish word (action 2) ranks all NUM_ITEMS
// items by descending support, ties to the smaller item id, then sends one result
// word per item in rank order with its support, frequent flag, the frequent item
// count and the mining size limit, and finally clears the counters and the
// largest size. ranking uses one comparator in the rank unit fed from the single
// read port of the counter memory: each item is compared against every item, and
// each result word is fetched through the erd1, erd2 and eload states and then
// held until the receiver takes it with out_ready high.
// in_ready is low from the finish word until the last result word is taken.
// counters need no clearing pass: one valid flop per counter stands in for zero.
// configuration writes are taken at any time (cfg_ready stays high); index 0 is
// min_support, index 1 is expected_k, other indexes are dropped
`include "assert_macros.svh"

module frequent_item_support_ranker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  fisr_pkg::fisr_in_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output fisr_pkg::fisr_out_t            out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fisr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fisr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fisr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INC,
        ST_PIV,
        ST_LOAD,
        ST_SCAN,
        ST_WRITE,
        ST_ERD1,
        ST_ERD2,
        ST_ELOAD,
        ST_EWAIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [ITEM_IDX_W-1:0]  i_reg, i_next;          // pivot item during ranking
    logic [ITEM_IDX_W:0]    j_reg, j_next;          // candidate read pointer
    logic [ITEM_IDX_W-1:0]  r_reg, r_next;          // rank being sent
    logic [FREQ_W-1:0]      freq_reg, freq_next;
    logic [TSIZE_W-1:0]     largest_reg, largest_next;
    logic [MINSUP_W-1:0]    min_support_reg, min_support_next;
    logic [EXPK_W-1:0]      expected_k_reg, expected_k_next;
    logic [NUM_ITEMS-1:0]   sup_vld_reg, sup_vld_next;
    logic                   out_valid_reg, out_valid_next;
    fisr_out_t              out_data_reg, out_data_next;

    // support counter memory, one read and one write port
    logic [SUPPORT_BITS-1:0] sup_mem [NUM_ITEMS];
    logic [ITEM_IDX_W-1:0]   rd_addr;
    logic [SUPPORT_BITS-1:0] rd_data_reg;
    logic                    rd_vld_reg;
    logic [ITEM_IDX_W-1:0]   rd_id_reg;
    logic                    sup_we;
    logic [SUPPORT_BITS-1:0] rd_sup;
    logic [SUPPORT_BITS-1:0] sup_inc;

    // rank order memory, written during ranking, read while sending
    logic [ITEM_IDX_W-1:0]   rank_mem [NUM_ITEMS];
    logic                    rank_we;
    logic [ITEM_IDX_W-1:0]   rk_item_reg;

    fisr_rank_ctl_t          rank_ctl;
    logic [ITEM_IDX_W-1:0]   rank_pos;
    logic                    thr_meet;
    logic                    id_ok;
    logic [TSIZE_W-1:0]      size_limit;

    // a counter never written since the last clear reads as zero
    assign rd_sup   = rd_vld_reg ? rd_data_reg : '0;
    assign sup_inc  = (rd_sup == SUPPORT_MAX) ? rd_sup : rd_sup + 1'b1;
    assign thr_meet = THR_W'(rd_sup) >= THR_W'(min_support_reg);
    assign id_ok    = 32'(in_data.item_id) < NUM_ITEMS;

    // expected_k of zero, or above the largest size, falls back to the largest size
    assign size_limit = ((expected_k_reg == '0) || (largest_reg < expected_k_reg))
                        ? largest_reg : TSIZE_W'(expected_k_reg);

    always_ff @(posedge clk)
    begin
        if (sup_we)
        begin
            sup_mem[rd_id_reg] <= sup_inc;
        end
        rd_data_reg <= sup_mem[rd_addr];
        rd_vld_reg  <= sup_vld_reg[rd_addr];
        rd_id_reg   <= rd_addr;
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_mem[rank_pos] <= i_reg;
        end
        rk_item_reg <= rank_mem[r_reg];
    end

    fisr_rank_unit u_rank (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (rank_ctl),
        .sup   (rd_sup),
        .id    (rd_id_reg),
        .pos   (rank_pos)
    );

    always_comb
    begin
        state_next       = state_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        r_next           = r_reg;
        freq_next        = freq_reg;
        largest_next     = largest_reg;
        min_support_next = min_support_reg;
        expected_k_next  = expected_k_reg;
        sup_vld_next     = sup_vld_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        rd_addr          = '0;
        sup_we           = 1'b0;
        rank_we          = 1'b0;
        rank_ctl         = '0;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MIN_SUPPORT: min_support_next = MINSUP_W'(cfg_data);
                CFG_EXPECTED_K:  expected_k_next  = EXPK_W'(cfg_data);
                default:         ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = in_data.item_id[ITEM_IDX_W-1:0];
                if (in_valid)
                begin
                    case (in_data.action)
                        ACT_HEADER:
                        begin
                            if (in_data.trans_size > largest_reg)
                            begin
                                largest_next = in_data.trans_size;
                            end
                        end
                        ACT_ITEM:
                        begin
                            if (id_ok)
                            begin
                                state_next = ST_INC;
                            end
                        end
                        ACT_FINISH:
                        begin
                            i_next     = '0;
                            freq_next  = '0;
                            state_next = ST_PIV;
                        end
                        default: ;
                    endcase
                end
            end
            ST_INC:
            begin
                // counter read last cycle, write back the saturated increment
                sup_we                  = 1'b1;
                sup_vld_next[rd_id_reg] = 1'b1;
                state_next              = ST_IDLE;
            end
            ST_PIV:
            begin
                rd_addr    = i_reg;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                rank_ctl.load = 1'b1;
                if (thr_meet)
                begin
                    freq_next = FREQ_W'(freq_reg + 1'b1);
                end
                rd_addr    = '0;
                j_next     = (ITEM_IDX_W + 1)'(1);
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // compare the candidate read last cycle, fetch the next one
                rank_ctl.step = 1'b1;
                if (j_reg == (ITEM_IDX_W + 1)'(NUM_ITEMS))
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    rd_addr = j_reg[ITEM_IDX_W-1:0];
                    j_next  = j_reg + 1'b1;
                end
            end
            ST_WRITE:
            begin
                rank_we = 1'b1;
                if (i_reg == ITEM_IDX_W'(NUM_ITEMS - 1))
                begin
                    r_next     = '0;
                    state_next = ST_ERD1;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_PIV;
                end
            end
            ST_ERD1:
            begin
                state_next = ST_ERD2;
            end
            ST_ERD2:
            begin
                rd_addr    = rk_item_reg;
                state_next = ST_ELOAD;
            end
            ST_ELOAD:
            begin
                out_data_next.rank           = RANK_W'(r_reg);
                out_data_next.ranked_item    = ID_W'(rd_id_reg);
                out_data_next.item_support   = SUP_FLD_W'(rd_sup);
                out_data_next.is_frequent    = thr_meet;
                out_data_next.frequent_count = FCOUNT_W'(freq_reg);
                out_data_next.size_limit     = size_limit;
                out_data_next.last           = (r_reg == ITEM_IDX_W'(NUM_ITEMS - 1));
                out_valid_next               = 1'b1;
                state_next                   = ST_EWAIT;
            end
            ST_EWAIT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (r_reg == ITEM_IDX_W'(NUM_ITEMS - 1))
                    begin
                        // run done: clear counters and largest size
                        sup_vld_next = '0;
                        largest_next = '0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        r_next     = r_reg + 1'b1;
                        state_next = ST_ERD1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            i_reg           <= '0;
            j_reg           <= '0;
            r_reg           <= '0;
            freq_reg        <= '0;
            largest_reg     <= '0;
            min_support_reg <= MINSUP_W'(1);
            expected_k_reg  <= '0;
            sup_vld_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            i_reg           <= i_next;
            j_reg           <= j_next;
            r_reg           <= r_next;
            freq_reg        <= freq_next;
            largest_reg     <= largest_next;
            min_support_reg <= min_support_next;
            expected_k_reg  <= expected_k_next;
            sup_vld_reg     <= sup_vld_next;
            out_valid_reg   <= out_valid_next;
            out_data_reg    <= out_data_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // input side stays closed while a result word is pending
    `FISR_ASSERT(a_no_overlap, !(in_ready && out_valid), "input open while result pending")
    // taking the final word clears every counter and reopens the input
    `FISR_ASSERT_NEXT(a_clear_on_last, out_valid && out_ready && out_data.last,
        in_ready && (sup_vld_reg == '0) && (largest_reg == '0), "run state not cleared")
    // the last flag marks the final rank only
    `FISR_ASSERT(a_last_rank, !out_valid || (out_data.last == (out_data.rank == RANK_W'(NUM_ITEMS - 1))), "last flag off its rank")

endmodule

[dv/frequent_item_support_ranker_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench of frequent_item_support_ranker: directed and random words
// against a cycle-free predictor of supports and rankings; depends on fisr_pkg and the rtl
module frequent_item_support_ranker_tb;

    import fisr_pkg::*;

    // spare register indexes, dropped by the block
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);
    // action code with no meaning, the block ignores it
    localparam logic [ACTION_W-1:0] ACT_UNUSED = ACTION_W'(3);

    // an item word can still be in flight after the last result word
    localparam int DRAIN_CYCLES = 16;
    localparam int TAIL_CYCLES  = 20;
    localparam longint unsigned TIMEOUT_NS = 100_000_000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    fisr_in_t  in_data;
    logic      out_valid;
    logic      out_ready;
    fisr_out_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor state: per item support, largest transaction, registers
    logic [SUPPORT_BITS-1:0] support_tally [NUM_ITEMS];
    logic [TSIZE_W-1:0]      largest_size;
    logic [MINSUP_W-1:0]     min_support_reg;
    logic [EXPK_W-1:0]       expected_k_reg;

    // ranked result words still to come, oldest first
    fisr_out_t ranking_q [$];

    // 0 no idling, 1 sparse, 2 heavy; shared by sender and receiver
    int idle_level;
    int mismatch_count;
    int words_sent;
    int finishes_sent;
    int results_seen;

    frequent_item_support_ranker i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case a handshake never completes
    initial
    begin
        #(TIMEOUT_NS);
        $display("frequent_item_support_ranker_tb failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
    endtask

    // ranking on finish: position = number of items that rank ahead
    task automatic rank_supports();
        logic [ID_W-1:0]     order [NUM_ITEMS];
        int                  pos;
        logic [FCOUNT_W-1:0] freq;
        logic [TSIZE_W-1:0]  limit;
        fisr_out_t           r;
        freq = '0;
        for (int i = 0; i < NUM_ITEMS; i++)
        begin
            pos = 0;
            for (int j = 0; j < NUM_ITEMS; j++)
            begin
                // higher support first, ties to the smaller id
                if (j != i && (support_tally[j] > support_tally[i] ||
                               (support_tally[j] == support_tally[i] && j < i)))
                    pos++;
            end
            order[pos] = ID_W'(i);
            if (support_tally[i] >= min_support_reg)
                freq++;
        end
        // zero or oversized request falls back to the largest transaction
        if (expected_k_reg == '0 || largest_size < expected_k_reg)
            limit = largest_size;
        else
            limit = expected_k_reg;
        for (int i = 0; i < NUM_ITEMS; i++)
        begin
            r.rank           = RANK_W'(i);
            r.ranked_item    = order[i];
            r.item_support   = SUP_FLD_W'(support_tally[order[i]]);
            r.is_frequent    = (support_tally[order[i]] >= min_support_reg);
            r.frequent_count = freq;
            r.size_limit     = limit;
            r.last           = (i == NUM_ITEMS - 1);
            ranking_q.insert(ranking_q.size(), r);
        end
        // next run starts from scratch
        for (int i = 0; i < NUM_ITEMS; i++)
            support_tally[i] = '0;
        largest_size = '0;
        finishes_sent++;
    endtask

    task automatic predict_word(input fisr_in_t w);
        case (w.action)
            ACT_HEADER:
                if (w.trans_size > largest_size)
                    largest_size = w.trans_size;
            ACT_ITEM:
                // saturating count
                if (support_tally[w.item_id] != SUPPORT_MAX)
                    support_tally[w.item_id] = support_tally[w.item_id] + 1'b1;
            ACT_FINISH:
                rank_supports();
            default:
                ;
        endcase
    endtask

    function automatic fisr_in_t make_word(input logic [ACTION_W-1:0] act,
                                           input logic [TSIZE_W-1:0] tsize,
                                           input logic [ID_W-1:0] id);
        fisr_in_t w;
        w.action     = act;
        w.trans_size = tsize;
        w.item_id    = id;
        return w;
    endfunction

    // one input word; valid is only lowered ahead of an idle burst or a drain
    task automatic send_word(input fisr_in_t w);
        if (idle_level != 0 && $urandom_range(0, (idle_level == 1) ? 7 : 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_word(w);
        words_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_MIN_SUPPORT)
            min_support_reg = data[MINSUP_W-1:0];
        else if (idx == CFG_EXPECTED_K)
            expected_k_reg = data[EXPK_W-1:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // sender holds off until every ranked word is back, then lets the pipe settle
    task automatic wait_ranking_drained();
        in_valid <= 1'b0;
        while (ranking_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // reset registers, an ignored action code, finish with nothing counted
    task automatic test_empty_finish();
        send_word(make_word(ACT_UNUSED, '1, '1));
        send_word(make_word(ACT_FINISH, '0, '0));
        wait_ranking_drained();
    endtask

    // ties, extreme ids and sizes, item without header, size limit from expected_k
    task automatic test_directed_counts();
        write_reg(CFG_MIN_SUPPORT, CFG_DATA_W'(2));
        write_reg(CFG_EXPECTED_K, CFG_DATA_W'(5));
        write_reg(CFG_SPARE_LO, '1);
        send_word(make_word(ACT_HEADER, TSIZE_W'(3), '1));
        send_word(make_word(ACT_ITEM, '0, ID_W'(0)));
        send_word(make_word(ACT_ITEM, '1, ID_W'(63)));
        send_word(make_word(ACT_ITEM, '0, ID_W'(63)));
        send_word(make_word(ACT_ITEM, '0, ID_W'(5)));
        send_word(make_word(ACT_ITEM, '0, ID_W'(5)));
        send_word(make_word(ACT_ITEM, '0, ID_W'(5)));
        send_word(make_word(ACT_HEADER, '1, '0));
        send_word(make_word(ACT_HEADER, '0, '0));
        // 9 ties with 63 and no header announced it
        send_word(make_word(ACT_ITEM, '0, ID_W'(9)));
        send_word(make_word(ACT_ITEM, '0, ID_W'(9)));
        send_word(make_word(ACT_UNUSED, '0, ID_W'(9)));
        send_word(make_word(ACT_FINISH, '1, '1));
        wait_ranking_drained();
    endtask

    // zero threshold marks all items frequent, oversized expected_k falls back
    task automatic test_threshold_extremes();
        write_reg(CFG_MIN_SUPPORT, '0);
        write_reg(CFG_EXPECTED_K, CFG_DATA_W'(255));
        write_reg(CFG_SPARE_HI, CFG_DATA_W'(1));
        send_word(make_word(ACT_HEADER, TSIZE_W'(7), '0));
        send_word(make_word(ACT_ITEM, '0, ID_W'(1)));
        send_word(make_word(ACT_ITEM, '0, ID_W'(62)));
        send_word(make_word(ACT_FINISH, '0, '0));
        wait_ranking_drained();
    endtask

    // one counter well ahead at full rate, full-scale threshold marks nothing frequent
    task automatic test_full_scale_threshold();
        int saved_level;
        saved_level = idle_level;
        idle_level = 0;
        write_reg(CFG_MIN_SUPPORT, '1);
        write_reg(CFG_EXPECTED_K, CFG_DATA_W'(200));
        send_word(make_word(ACT_HEADER, '1, '0));
        repeat (30)
            send_word(make_word(ACT_ITEM, '0, ID_W'(42)));
        repeat (3)
            send_word(make_word(ACT_ITEM, '0, ID_W'(7)));
        send_word(make_word(ACT_FINISH, '0, '0));
        wait_ranking_drained();
        idle_level = saved_level;
    endtask

    // random mining runs: mostly well-formed transactions around a hot set of ids,
    // some mismatched headers, stray items and ignored words
    task automatic test_random_runs(input int word_goal, input bit allow_idle);
        int counted;
        int tsize;
        int n_items;
        int hot;
        counted = 0;
        while (counted < word_goal)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                wait_ranking_drained();
                case ($urandom_range(0, 5))
                    0: write_reg(CFG_MIN_SUPPORT, '0);
                    1: write_reg(CFG_MIN_SUPPORT, '1);
                    2: write_reg(CFG_MIN_SUPPORT, CFG_DATA_W'($urandom_range(1, 4)));
                    3: write_reg(CFG_MIN_SUPPORT, CFG_DATA_W'($urandom()));
                    default: write_reg(CFG_MIN_SUPPORT, CFG_DATA_W'($urandom_range(1, 12)));
                endcase
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_EXPECTED_K, '0);
                    1: write_reg(CFG_EXPECTED_K, CFG_DATA_W'(255));
                    2: write_reg(CFG_EXPECTED_K, CFG_DATA_W'($urandom_range(1, 8)));
                    default: write_reg(CFG_EXPECTED_K, CFG_DATA_W'($urandom()));
                endcase
                if ($urandom_range(0, 7) == 0)
                    write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI,
                              CFG_DATA_W'($urandom()));
            end
            idle_level = allow_idle ? $urandom_range(0, 2) : 0;
            hot = $urandom_range(0, NUM_ITEMS - 1);
            repeat ($urandom_range(1, 5))
            begin
                tsize = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(1, 8);
                send_word(make_word(ACT_HEADER, TSIZE_W'(tsize), ID_W'($urandom())));
                counted++;
                // broken transactions draw their item count at random, not from the header
                if ($urandom_range(0, 5) == 0)
                    n_items = $urandom_range(0, 10);
                else
                    n_items = (tsize > 8) ? $urandom_range(1, 8) : tsize;
                repeat (n_items)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_word(make_word(ACT_UNUSED, TSIZE_W'($urandom()),
                                            ID_W'($urandom())));
                    if ($urandom_range(0, 3) == 0)
                        send_word(make_word(ACT_ITEM, TSIZE_W'($urandom()),
                                            ID_W'($urandom_range(0, NUM_ITEMS - 1))));
                    else
                        send_word(make_word(ACT_ITEM, TSIZE_W'($urandom()),
                                            ID_W'(hot + $urandom_range(0, 3))));
                    counted++;
                end
            end
            // stray items after the last transaction
            if ($urandom_range(0, 4) == 0)
            begin
                send_word(make_word(ACT_ITEM, '0, ID_W'($urandom())));
                counted++;
            end
            send_word(make_word(ACT_FINISH, TSIZE_W'($urandom()), ID_W'($urandom())));
            counted++;
        end
        wait_ranking_drained();
    endtask

    // receiver: random stall bursts, calm stretches, always ready when idling is off
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_level != 0 && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                repeat ($urandom_range(20, 120)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // result checker: each accepted word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (ranking_q.size() == 0)
            begin
                report_mismatch("unexpected result word, rank", 32'(out_data.rank), 0);
            end
            else
            begin
                fisr_out_t want;
                want = ranking_q.pop_front();
                results_seen++;
                if (out_data.rank != want.rank)
                    report_mismatch("rank", 32'(out_data.rank), 32'(want.rank));
                if (out_data.ranked_item != want.ranked_item)
                    report_mismatch("ranked_item", 32'(out_data.ranked_item),
                                    32'(want.ranked_item));
                if (out_data.item_support != want.item_support)
                    report_mismatch("item_support", 32'(out_data.item_support),
                                    32'(want.item_support));
                if (out_data.is_frequent != want.is_frequent)
                    report_mismatch("is_frequent", 32'(out_data.is_frequent),
                                    32'(want.is_frequent));
                if (out_data.frequent_count != want.frequent_count)
                    report_mismatch("frequent_count", 32'(out_data.frequent_count),
                                    32'(want.frequent_count));
                if (out_data.size_limit != want.size_limit)
                    report_mismatch("size_limit", 32'(out_data.size_limit),
                                    32'(want.size_limit));
                if (out_data.last != want.last)
                    report_mismatch("last", 32'(out_data.last), 32'(want.last));
            end
        end
    end

    initial
    begin
        // predictor mirrors the reset state
        for (int i = 0; i < NUM_ITEMS; i++)
            support_tally[i] = '0;
        largest_size    = '0;
        min_support_reg = MINSUP_W'(1);
        expected_k_reg  = '0;
        idle_level      = 1;
        mismatch_count  = 0;
        words_sent      = 0;
        finishes_sent   = 0;
        results_seen    = 0;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_finish();
        test_directed_counts();
        test_threshold_extremes();
        test_full_scale_threshold();
        test_random_runs(380, 1'b1);
        // last stretch at full rate on both sides
        test_random_runs(40, 1'b0);

        while (ranking_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d input words and %0d finishes, %0d ranked words checked",
                 words_sent, finishes_sent, results_seen);
        $display("including ties, stray items, zero and full-scale thresholds");
        if (mismatch_count == 0)
            $display("frequent_item_support_ranker_tb passed");
        else
            $display("frequent_item_support_ranker_tb failed");
        $finish;
    end

endmodule

[frequent_item_support_ranker.f]
+incdir+rtl
rtl/fisr_pkg.sv
rtl/fisr_rank_unit.sv
rtl/frequent_item_support_ranker.sv
dv/frequent_item_support_ranker_tb.sv
